[design/lphs_pkg.sv]
// Shared types and constants of the linear-probing hash set.
// Used by the channel interfaces, the modulo unit and the top level.
package lphs_pkg;

   localparam int KEY_W    = 31;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 6;
   localparam int SIZE_W   = 7;
   localparam int MARK_W   = 2;
   localparam int SIZE_MAX = 127;
   localparam int CNT_W    = $clog2(KEY_W + 1);

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd5;

   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [SIZE_W-1:0] remainder;
   } mod_rsp_type;

endpackage

[design/lphs_req_if.sv]
// Request channel of the hash set: operation and key with valid/ready.
// Depends on lphs_pkg.
interface lphs_req_if import lphs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [KEY_W-1:0] key;

   modport source (output valid, output op, output key, input ready);
   modport sink   (input valid, input op, input key, output ready);
endinterface

[design/lphs_rsp_if.sv]
// Response channel of the hash set: status, key and slot with valid/ready.
// Depends on lphs_pkg.
interface lphs_rsp_if import lphs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KEY_W-1:0]    key_out;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, output status, output key_out, output slot, input ready);
   modport sink   (input valid, input status, input key_out, input slot, output ready);
endinterface

[design/linear_probe_hash_set_unit.sv]
// Channel  Dir  Transfer fields               Notes
// req_bus  in   op, key                       one request per transfer
// rsp_bus  out  status, key_out, slot         exactly one response per request
// csr_*    in   write_en, write_data (size)   write only while idle
//
// Steps: accept, the bit-serial modulo, then one probed slot per cycle (up to the
// table size) on the one read and one write port of the slot memory, then a load
// of the response register.
// An unused operation code skips the modulo and probing and answers not found.
// Reset: synchronous; a clearing pass over all SLOTS slots marks every slot empty
// and holds req_bus.ready low. A stalled response holds; the next request is
// accepted meanwhile and waits in its result state.
// Depends on lphs_pkg, lphs_req_if, lphs_rsp_if and lphs_mod_unit.
module linear_probe_hash_set_unit import lphs_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   lphs_req_if.sink          req_bus,
   lphs_rsp_if.source        rsp_bus,
   input  logic              csr_write_en,
   input  logic [SIZE_W-1:0] csr_write_data
);

   localparam int AW    = $clog2(SLOTS);
   localparam int MEM_W = MARK_W + KEY_W;
   localparam logic [SIZE_W-1:0] SIZE_CAP  = SIZE_W'((SLOTS > SIZE_MAX) ? SIZE_MAX : SLOTS);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_RESULT
   } state_type;

   state_type           state_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [AW-1:0]       clr_ff;
   logic [OP_W-1:0]     op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [SIZE_W-1:0]   idx_ff;
   logic [SIZE_W-1:0]   step_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [KEY_W-1:0]    res_key_ff;
   logic [SLOT_W-1:0]   res_slot_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [MEM_W-1:0]    rd_data_ff;
   logic [MEM_W-1:0]    mem [SLOTS];

   logic [SIZE_W-1:0]   n_eff;
   logic [SIZE_W-1:0]   n_last;
   logic [SIZE_W-1:0]   idx_in;
   logic                req_accept;
   logic                op_known;
   logic [MARK_W-1:0]   rd_mark;
   logic [KEY_W-1:0]    rd_key;
   logic                slot_free;
   logic                key_hit;
   logic                probe_last;
   logic                rsp_load;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [MEM_W-1:0]    wr_data;
   mod_req_type         mod_req;
   mod_rsp_type         mod_rsp;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_write_en) begin
         size_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_CAP) begin
         n_eff = SIZE_CAP;
      end else begin
         n_eff = size_ff;
      end
      n_last = n_eff - SIZE_W'(1);
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      case (req_bus.op)
         OP_INSERT, OP_DELETE, OP_SEARCH: op_known = 1'b1;
         default:                         op_known = 1'b0;
      endcase
   end

   assign mod_req.start    = req_accept && op_known;
   assign mod_req.dividend = req_bus.key;
   assign mod_req.divisor  = n_eff;

   lphs_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   // probe decode of the slot just read
   assign rd_mark    = rd_data_ff[MEM_W-1 -: MARK_W];
   assign rd_key     = rd_data_ff[KEY_W-1:0];
   assign slot_free  = (rd_mark != MARK_USED);
   assign key_hit    = (rd_mark == MARK_USED) && (rd_key == key_ff);
   assign probe_last = (step_ff == n_last);
   assign idx_in     = (idx_ff == n_last) ? '0 : idx_ff + SIZE_W'(1);
   assign rsp_load   = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_bus.ready);

   // read ahead: the home slot when the modulo ends, else the next probe slot
   assign rd_addr = (state_ff == ST_HASH) ? AW'(mod_rsp.remainder) : AW'(idx_in);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(idx_ff);
      wr_data = {MARK_USED, key_ff};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {MARK_EMPTY, KEY_W'(0)};
         end
         ST_PROBE: begin
            case (op_ff)
               OP_INSERT: wr_en = slot_free;
               OP_DELETE: begin
                  wr_en   = key_hit;
                  wr_data = {MARK_GONE, rd_key};
               end
               default: wr_en = 1'b0;
            endcase
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  op_ff  <= req_bus.op;
                  key_ff <= req_bus.key;
                  if (op_known) begin
                     state_ff <= ST_HASH;
                  end else begin
                     res_status_ff <= STATUS_NOT_FOUND;
                     res_key_ff    <= '0;
                     res_slot_ff   <= '0;
                     state_ff      <= ST_RESULT;
                  end
               end
            end
            ST_HASH: begin
               if (mod_rsp.done) begin
                  idx_ff   <= mod_rsp.remainder;
                  step_ff  <= '0;
                  state_ff <= ST_PROBE;
               end
            end
            ST_PROBE: begin
               if ((op_ff == OP_INSERT) ? slot_free : key_hit) begin
                  res_status_ff <= STATUS_OK;
                  res_key_ff    <= key_ff;
                  res_slot_ff   <= idx_ff[SLOT_W-1:0];
                  state_ff      <= ST_RESULT;
               end else if (((op_ff != OP_INSERT) && (rd_mark == MARK_EMPTY)) || probe_last) begin
                  res_status_ff <= (op_ff == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
                  res_key_ff    <= '0;
                  res_slot_ff   <= '0;
                  state_ff      <= ST_RESULT;
               end else begin
                  // advance to the next slot; its read is already under way
                  idx_ff  <= idx_in;
                  step_ff <= step_ff + SIZE_W'(1);
               end
            end
            ST_RESULT: begin
               // hold until the response register is free
               if (rsp_load) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_key_ff    <= res_key_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.status  = rsp_status_ff;
   assign rsp_bus.key_out = rsp_key_ff;
   assign rsp_bus.slot    = rsp_slot_ff;

   a_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (state_ff == ST_HASH))
      else $error("modulo result outside the hash state");

   a_home_in_range: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (mod_rsp.remainder < n_eff))
      else $error("home slot beyond table size");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> ((idx_ff < n_eff) && (step_ff < n_eff)))
      else $error("probe index or step count out of range");

   a_fail_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK))
         |-> ((rsp_key_ff == '0) && (rsp_slot_ff == '0)))
      else $error("failed response carries a key or slot");

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      mod_req.start |=> ((state_ff == ST_HASH) && mod_rsp.busy))
      else $error("accepted request did not start the modulo");

endmodule

[design/lphs_mod_unit.sv]
// Bit-serial restoring modulo: key modulo table size, one key bit per cycle.
// Depends on lphs_pkg.
module lphs_mod_unit import lphs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type mod_req,
   output mod_rsp_type mod_rsp
);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [KEY_W-1:0]  shift_ff;
   logic [SIZE_W-1:0] div_ff;
   logic [SIZE_W-1:0] rem_ff;
   logic [SIZE_W-1:0] rem_in;
   logic [SIZE_W:0]   trial;

   always_comb begin
      trial = {rem_ff, shift_ff[KEY_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = SIZE_W'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mod_req.start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= CNT_W'(KEY_W);
            shift_ff <= mod_req.dividend;
            div_ff   <= mod_req.divisor;
            rem_ff   <= '0;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            shift_ff <= {shift_ff[KEY_W-2:0], 1'b0};
            cnt_ff   <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mod_rsp.busy      = busy_ff;
   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule
